>>> rtl/srrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrs_pkg: shared types for the staged row range set
// Command codes from the controller to the datapath and the status bundle
// the datapath returns.
// ----------------------------------------------------------------------------
package srrs_pkg;

  // Widths of the request and result fields on the ports.
  localparam int unsigned RowPortW = 48;
  localparam int unsigned CntPortW = 7;

  typedef enum logic [3:0] {
    CMD_IDLE     = 4'd0,
    CMD_LOAD     = 4'd1,
    CMD_STAGE    = 4'd2,
    CMD_CLOSE    = 4'd3,
    CMD_SRCH_RD  = 4'd4,
    CMD_SRCH_CMP = 4'd5,
    CMD_ENT_RD   = 4'd6,
    CMD_ENT_CHK  = 4'd7,
    CMD_RM_RD    = 4'd8,
    CMD_RM_WR    = 4'd9,
    CMD_RM_FIN   = 4'd10,
    CMD_SP_RD    = 4'd11,
    CMD_SP_WR    = 4'd12,
    CMD_SP_FIN   = 4'd13,
    CMD_OUT_LOAD = 4'd14
  } srrs_cmd_e;

  typedef struct packed {
    logic is_last;     // captured request closes its batch
    logic srch_done;   // binary search interval is empty
    logic lo_zero;     // search ended below the first range
    logic ent_remove;  // head hit empties the range
    logic ent_split;   // middle hit with room for the split
    logic rm_done;     // removal shift has reached the table end
    logic sp_done;     // split shift has opened the gap
  } srrs_stat_t;

endpackage
`default_nettype wire

>>> rtl/staged_row_range_set.sv
`timescale 1ns / 1ps
`default_nettype none
// A stage request is loaded, staged, closed as well if it ends a batch, and its result is loaded.
// A delete runs search probes (at most clog2(RANGES+1)), each a read and a compare, then reads and
// checks the found entry (skipped when the search ends below the first range) and loads the result; a
// removal or split adds a read and a write per entry shifted and a finishing step.
// Throughput: one request at a time; the next is accepted the cycle after the result is loaded.
// Reset clears the fill count and the open range; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// staged_row_range_set: sorted table of half-open row-id ranges
// Stage requests grow or close an open range and append closed ranges to the
// table; delete requests binary-search the table and trim, remove or split the
// range that holds the row id.
// ----------------------------------------------------------------------------
module staged_row_range_set #(
  parameter int unsigned RANGES   = 64,
  parameter int unsigned ROW_BITS = 48
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire                             mode_i,
  input  wire  [srrs_pkg::RowPortW-1:0]   row_id_i,
  input  wire                             last_in_batch_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            status_o,
  output logic                            hit_o,
  output logic [srrs_pkg::CntPortW-1:0]   closed_count_o,
  output logic                            has_staged_o,
  output logic [srrs_pkg::RowPortW-1:0]   oldest_start_o,
  output logic [srrs_pkg::RowPortW-1:0]   oldest_end_o
);
  import srrs_pkg::*;

  // The controller and the datapath talk only through a command code and a
  // small status bundle. The controller owns both handshakes: a request is
  // taken whenever the sequencer is idle, even while the previous result
  // still sits in the output register, and the new result is loaded into
  // that register only once the old one has been taken.
  srrs_cmd_e  cmd;
  srrs_stat_t stat;

  srrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the two range memories (one write and one registered
  // read per cycle), a register copy of the first entry so that the oldest
  // range is always at hand, the open range, and the search and shift
  // pointers. Closed ranges are appended at the fill count; removals and
  // splits move entries one at a time, a read followed by a write.
  srrs_dp #(
    .RANGES   (RANGES),
    .ROW_BITS (ROW_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mode_i          (mode_i),
    .row_id_i        (row_id_i),
    .last_in_batch_i (last_in_batch_i),
    .stat_o          (stat),
    .status_o        (status_o),
    .hit_o           (hit_o),
    .closed_count_o  (closed_count_o),
    .has_staged_o    (has_staged_o),
    .oldest_start_o  (oldest_start_o),
    .oldest_end_o    (oldest_end_o)
  );

  // A request is never followed by a second acceptance in the next cycle,
  // since every request needs at least one working step.
  a_single_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request accepted while the first is in progress");

  // A table holding ranges always reports staged rows.
  a_count_staged : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (closed_count_o != '0)) |-> has_staged_o)
    else $error("ranges held but nothing reported as staged");

  // With nothing staged the oldest range reads as zero.
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_staged_o) |-> ((oldest_start_o == '0) && (oldest_end_o == '0)))
    else $error("oldest range non-zero with nothing staged");

endmodule
`default_nettype wire

>>> rtl/srrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrs_ctrl: sequencer of the staged row range set
// Steps the datapath through staging, binary search and table shifts, and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
module srrs_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire                    mode_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  input  srrs_pkg::srrs_stat_t   stat_i,
  output srrs_pkg::srrs_cmd_e    cmd_o
);
  import srrs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_STAGE = 11'b000_0000_0010,
    S_CLOSE = 11'b000_0000_0100,
    S_SRCH  = 11'b000_0000_1000,
    S_CMP   = 11'b000_0001_0000,
    S_CHK   = 11'b000_0010_0000,
    S_RM    = 11'b000_0100_0000,
    S_RMW   = 11'b000_1000_0000,
    S_SP    = 11'b001_0000_0000,
    S_SPW   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load_out;

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_IDLE;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = mode_i ? S_SRCH : S_STAGE;
        end
      end
      S_STAGE: begin
        cmd_o   = CMD_STAGE;
        state_d = stat_i.is_last ? S_CLOSE : S_DONE;
      end
      S_CLOSE: begin
        cmd_o   = CMD_CLOSE;
        state_d = S_DONE;
      end
      S_SRCH: begin
        if (!stat_i.srch_done) begin
          cmd_o   = CMD_SRCH_RD;
          state_d = S_CMP;
        end else if (stat_i.lo_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_ENT_RD;
          state_d = S_CHK;
        end
      end
      S_CMP: begin
        cmd_o   = CMD_SRCH_CMP;
        state_d = S_SRCH;
      end
      S_CHK: begin
        cmd_o = CMD_ENT_CHK;
        if (stat_i.ent_remove) begin
          state_d = S_RM;
        end else if (stat_i.ent_split) begin
          state_d = S_SP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RM: begin
        if (stat_i.rm_done) begin
          cmd_o   = CMD_RM_FIN;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_RM_RD;
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        cmd_o   = CMD_RM_WR;
        state_d = S_RM;
      end
      S_SP: begin
        if (stat_i.sp_done) begin
          cmd_o   = CMD_SP_FIN;
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_SP_RD;
          state_d = S_SPW;
        end
      end
      S_SPW: begin
        cmd_o   = CMD_SP_WR;
        state_d = S_SP;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o    = CMD_OUT_LOAD;
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/srrs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrs_dp: datapath of the staged row range set
// Range table memories, open range, search bounds, shift pointer and the
// result register, all driven by controller commands.
// ----------------------------------------------------------------------------
module srrs_dp #(
  parameter int unsigned RANGES   = 64,
  parameter int unsigned ROW_BITS = 48
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  srrs_pkg::srrs_cmd_e                 cmd_i,
  input  wire                                 mode_i,
  input  wire  [srrs_pkg::RowPortW-1:0]       row_id_i,
  input  wire                                 last_in_batch_i,
  output srrs_pkg::srrs_stat_t                stat_o,
  output logic                                status_o,
  output logic                                hit_o,
  output logic [srrs_pkg::CntPortW-1:0]       closed_count_o,
  output logic                                has_staged_o,
  output logic [srrs_pkg::RowPortW-1:0]       oldest_start_o,
  output logic [srrs_pkg::RowPortW-1:0]       oldest_end_o
);
  import srrs_pkg::*;

  localparam int unsigned IW = $clog2(RANGES);
  localparam int unsigned CW = $clog2(RANGES + 1);
  localparam int unsigned RB = ROW_BITS;

  // Range table.
  logic [RB-1:0] starts_mem_q [RANGES];
  logic [RB-1:0] ends_mem_q   [RANGES];
  logic [RB-1:0] rd_start_q, rd_end_q;
  logic          we_s, we_e, re;
  logic [IW-1:0] waddr, raddr;
  logic [RB-1:0] wd_s, wd_e;

  // Copy of the first entry for the oldest-range result.
  logic [RB-1:0] head_start_q, head_end_q;

  // Request and working registers.
  logic [RB-1:0] id_q;
  logic          last_q;
  logic [CW-1:0] lo_q, hi_q, used_q;
  logic [IW-1:0] mid_q, idx_q, j_q;
  logic [RB-1:0] split_end_q;
  logic [RB-1:0] open_start_q, open_end_q;
  logic          open_valid_q;
  logic          status_q, hit_q;

  logic [RB+RowPortW-1:0] id_ext;
  logic [RB-1:0]          id_in, id_inc;
  logic                   id_max, room, extend;
  logic [CW:0]            mid_sum;
  logic [CW-1:0]          mid_w, lo_m1;
  logic [IW-1:0]          mid_c, idx_p1;
  logic                   in_rng, is_head, is_tail, is_mid, do_remove;

  logic [RB-1:0]          old_s, old_e;
  logic [RB+RowPortW-1:0] old_s_ext, old_e_ext;
  logic [CW+CntPortW-1:0] cnt_ext;

  assign id_ext  = {{RB{1'b0}}, row_id_i};
  assign id_in   = id_ext[RB-1:0];
  assign id_inc  = id_q + RB'(1);
  assign id_max  = &id_q;
  assign room    = (used_q < CW'(RANGES));
  assign extend  = open_valid_q && (id_q == open_end_q);

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w   = mid_sum[CW:1];
  assign mid_c   = mid_w[IW-1:0];
  assign lo_m1   = lo_q - CW'(1);
  assign idx_p1  = idx_q + IW'(1);

  // Classification of the entry read for a delete.
  assign in_rng    = (id_q >= rd_start_q) && (id_q < rd_end_q);
  assign is_head   = in_rng && (rd_start_q == id_q);
  assign is_tail   = in_rng && !is_head && (rd_end_q == id_inc);
  assign is_mid    = in_rng && !is_head && !is_tail;
  assign do_remove = is_head && (id_inc == rd_end_q);

  assign stat_o.is_last    = last_q;
  assign stat_o.srch_done  = (lo_q >= hi_q);
  assign stat_o.lo_zero    = (lo_q == '0);
  assign stat_o.ent_remove = do_remove;
  assign stat_o.ent_split  = is_mid && room;
  assign stat_o.rm_done    = ((CW'(j_q) + CW'(1)) >= used_q);
  assign stat_o.sp_done    = (CW'(j_q) <= (CW'(idx_q) + CW'(1)));

  // Memory port control.
  always_comb begin
    we_s  = 1'b0;
    we_e  = 1'b0;
    re    = 1'b0;
    waddr = used_q[IW-1:0];
    raddr = mid_c;
    wd_s  = open_start_q;
    wd_e  = open_end_q;
    unique case (cmd_i)
      CMD_STAGE: begin
        if (!id_max && !extend && open_valid_q && room) begin
          we_s = 1'b1;
          we_e = 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (open_valid_q && room) begin
          we_s = 1'b1;
          we_e = 1'b1;
        end
      end
      CMD_SRCH_RD: begin
        re = 1'b1;
      end
      CMD_ENT_RD: begin
        re    = 1'b1;
        raddr = lo_m1[IW-1:0];
      end
      CMD_ENT_CHK: begin
        waddr = idx_q;
        wd_s  = id_inc;
        wd_e  = id_q;
        we_s  = is_head && !do_remove;
        we_e  = is_tail || (is_mid && room);
      end
      CMD_RM_RD: begin
        re    = 1'b1;
        raddr = j_q + IW'(1);
      end
      CMD_RM_WR: begin
        we_s  = 1'b1;
        we_e  = 1'b1;
        waddr = j_q;
        wd_s  = rd_start_q;
        wd_e  = rd_end_q;
      end
      CMD_SP_RD: begin
        re    = 1'b1;
        raddr = j_q - IW'(1);
      end
      CMD_SP_WR: begin
        we_s  = 1'b1;
        we_e  = 1'b1;
        waddr = j_q;
        wd_s  = rd_start_q;
        wd_e  = rd_end_q;
      end
      CMD_SP_FIN: begin
        we_s  = 1'b1;
        we_e  = 1'b1;
        waddr = idx_p1;
        wd_s  = id_inc;
        wd_e  = split_end_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_s) begin
      starts_mem_q[waddr] <= wd_s;
    end
    if (we_e) begin
      ends_mem_q[waddr] <= wd_e;
    end
    if (re) begin
      rd_start_q <= starts_mem_q[raddr];
      rd_end_q   <= ends_mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_s && (waddr == '0)) begin
      head_start_q <= wd_s;
    end
    if (we_e && (waddr == '0)) begin
      head_end_q <= wd_e;
    end
  end

  // Table fill and open range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      open_start_q <= '0;
      open_end_q   <= '0;
      open_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i)
        CMD_STAGE: begin
          if (!id_max) begin
            if (extend) begin
              open_end_q <= id_inc;
            end else begin
              if (open_valid_q && room) begin
                used_q <= used_q + CW'(1);
              end
              open_start_q <= id_q;
              open_end_q   <= id_inc;
              open_valid_q <= 1'b1;
            end
          end
        end
        CMD_CLOSE: begin
          if (open_valid_q && room) begin
            used_q <= used_q + CW'(1);
          end
          open_start_q <= '0;
          open_end_q   <= '0;
          open_valid_q <= 1'b0;
        end
        CMD_RM_FIN: begin
          used_q <= used_q - CW'(1);
        end
        CMD_SP_FIN: begin
          used_q <= used_q + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of one request.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        id_q     <= id_in;
        last_q   <= last_in_batch_i && !mode_i;
        lo_q     <= '0;
        hi_q     <= used_q;
        status_q <= 1'b0;
        hit_q    <= 1'b0;
      end
      CMD_STAGE: begin
        if (!id_max && !extend && open_valid_q && !room) begin
          status_q <= 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (open_valid_q && !room) begin
          status_q <= 1'b1;
        end
      end
      CMD_SRCH_RD: begin
        mid_q <= mid_c;
      end
      CMD_SRCH_CMP: begin
        if (id_q < rd_start_q) begin
          hi_q <= CW'(mid_q);
        end else begin
          lo_q <= CW'(mid_q) + CW'(1);
        end
      end
      CMD_ENT_RD: begin
        idx_q <= lo_m1[IW-1:0];
      end
      CMD_ENT_CHK: begin
        hit_q    <= in_rng;
        status_q <= is_mid && !room;
        if (do_remove) begin
          j_q <= idx_q;
        end
        if (is_mid && room) begin
          j_q         <= used_q[IW-1:0];
          split_end_q <= rd_end_q;
        end
      end
      CMD_RM_WR: begin
        j_q <= j_q + IW'(1);
      end
      CMD_SP_WR: begin
        j_q <= j_q - IW'(1);
      end
      default: begin
      end
    endcase
  end

  // Result register.
  assign old_s     = (used_q != '0) ? head_start_q : open_start_q;
  assign old_e     = (used_q != '0) ? head_end_q : open_end_q;
  assign old_s_ext = {{RowPortW{1'b0}}, old_s};
  assign old_e_ext = {{RowPortW{1'b0}}, old_e};
  assign cnt_ext   = {{CntPortW{1'b0}}, used_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_OUT_LOAD) begin
      status_o       <= status_q;
      hit_o          <= hit_q;
      closed_count_o <= cnt_ext[CntPortW-1:0];
      has_staged_o   <= (used_q != '0) || open_valid_q;
      oldest_start_o <= old_s_ext[RowPortW-1:0];
      oldest_end_o   <= old_e_ext[RowPortW-1:0];
    end
  end

endmodule
`default_nettype wire
